// ===== hdl/ied_pkg.sv =====
// ----------------------------------------------------------------------------
// Impact event detector package
// Shared types, register indexes and encodings of the impact event detector.
// ----------------------------------------------------------------------------
package ied_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_BASELINE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS      = 3'd4;

  localparam logic [15:0] RST_GRAVITY_BASELINE = 16'd4096;
  localparam logic [15:0] RST_IMPACT_THRESHOLD = 16'd1434;
  localparam logic [15:0] RST_MEDIUM_THRESHOLD = 16'd2867;
  localparam logic [15:0] RST_HIGH_THRESHOLD   = 16'd4915;
  localparam logic [15:0] RST_COOLDOWN_MS      = 16'd500;

  localparam logic [31:0] ROOT_FIRST_BIT = 32'h4000_0000;

  typedef enum logic [1:0] {
    LVL_LOW    = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_HIGH   = 2'd2
  } level_t;

  typedef struct packed {
    logic [15:0] gravity_baseline;
    logic [15:0] impact_threshold;
    logic [15:0] medium_threshold;
    logic [15:0] high_threshold;
    logic [15:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sum_sq;
    logic [31:0] time_ms;
  } q_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_EVAL
  } back_state_t;

endpackage

// ===== hdl/ied_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one accelerometer sample and its timestamp.
// ----------------------------------------------------------------------------
interface ied_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [31:0] time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

// ===== hdl/ied_out_if.sv =====
// ----------------------------------------------------------------------------
// Impact event channel
// Valid/ready channel that carries one impact event.
// ----------------------------------------------------------------------------
interface ied_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  impact_level;
  logic [15:0] deviation;
  logic [31:0] event_time_ms;

  modport source (output valid, impact_level, deviation, event_time_ms, input ready);
  modport sink   (input valid, impact_level, deviation, event_time_ms, output ready);
endinterface

// ===== hdl/ied_front.sv =====
// ----------------------------------------------------------------------------
// Impact detector front end
// Accepts a sample and forms the sum of squares of the three axes with one
// shared multiplier, then hands the sum and timestamp to the queue.
// ----------------------------------------------------------------------------
module ied_front
  import ied_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ied_in_if.sink        in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output q_item_t       push_data
);

  front_state_t       state_r, state_nxt;
  logic         [1:0] cnt_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic        [31:0] time_r;
  logic        [30:0] sq_r;
  logic        [31:0] acc_r;
  logic signed [15:0] mul_op;
  logic signed [31:0] mul_res;
  logic               in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = F_CALC;
      F_CALC: if (cnt_r == 2'd3) state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    unique case (state_r)
      F_IDLE: in_ch.ready = 1'b1;
      F_PUSH: push_valid  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    case (cnt_r)
      2'd0:    mul_op = ax_r;
      2'd1:    mul_op = ay_r;
      default: mul_op = az_r;
    endcase
  end

  assign mul_res   = mul_op * mul_op;
  assign push_data = '{sum_sq: acc_r, time_ms: time_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r   <= in_ch.accel_x;
      ay_r   <= in_ch.accel_y;
      az_r   <= in_ch.accel_z;
      time_r <= in_ch.time_ms;
      cnt_r  <= 2'd0;
      acc_r  <= '0;
    end else if (state_r == F_CALC) begin
      sq_r  <= mul_res[30:0];
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r != 2'd0) begin
        acc_r <= acc_r + {1'b0, sq_r};
      end
    end
  end

endmodule

// ===== hdl/ied_fifo.sv =====
// ----------------------------------------------------------------------------
// Impact detector queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ied_fifo
  import ied_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_item_t            mem_r [DEPTH];
  logic   [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic   [CNT_W-1:0] count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/ied_back.sv =====
// ----------------------------------------------------------------------------
// Impact detector back end
// Takes the square root of the sum two bits per cycle, applies baseline,
// threshold and cooldown, and holds the event in the output register.
// ----------------------------------------------------------------------------
module ied_back
  import ied_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  q_item_t  pop_data,
  ied_out_if.source out_ch
);

  back_state_t state_r, state_nxt;
  logic [31:0] n_r, root_r, bit_r, time_r;
  logic [31:0] last_time_r;
  logic        oval_r;
  level_t      lvl_r;
  logic [15:0] dev_r;
  logic [31:0] etime_r;

  logic [31:0] trial;
  logic [15:0] mag, dev;
  logic [31:0] elapsed;
  logic        is_event, slot_free, load_out;
  level_t      lvl;

  assign trial     = root_r + bit_r;
  assign mag       = root_r[15:0];
  assign dev       = (mag >= cfg.gravity_baseline) ? mag - cfg.gravity_baseline
                                                   : cfg.gravity_baseline - mag;
  assign elapsed   = time_r - last_time_r;
  assign is_event  = (dev >= cfg.impact_threshold) && (elapsed >= {16'd0, cfg.cooldown_ms});
  assign slot_free = !oval_r || out_ch.ready;

  always_comb begin
    if (dev >= cfg.high_threshold) begin
      lvl = LVL_HIGH;
    end else if (dev >= cfg.medium_threshold) begin
      lvl = LVL_MEDIUM;
    end else begin
      lvl = LVL_LOW;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_ROOT;
      B_ROOT: if (bit_r[0]) state_nxt = B_EVAL;
      B_EVAL: if (!is_event || slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE: pop_ready = 1'b1;
      B_EVAL: load_out  = is_event && slot_free;
      default: ;
    endcase
  end

  assign out_ch.valid         = oval_r;
  assign out_ch.impact_level  = lvl_r;
  assign out_ch.deviation     = dev_r;
  assign out_ch.event_time_ms = etime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      oval_r      <= 1'b0;
      last_time_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        oval_r      <= 1'b1;
        last_time_r <= time_r;
      end else if (out_ch.ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      n_r    <= pop_data.sum_sq;
      time_r <= pop_data.time_ms;
      root_r <= '0;
      bit_r  <= ROOT_FIRST_BIT;
    end else if (state_r == B_ROOT) begin
      if (n_r >= trial) begin
        n_r    <= n_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (load_out) begin
      lvl_r   <= lvl;
      dev_r   <= dev;
      etime_r <= time_r;
    end
  end

endmodule

// ===== hdl/impact_event_detector.sv =====
// ----------------------------------------------------------------------------
// Impact event detector
// Flags accelerometer samples whose magnitude departs from gravity by at least
// a threshold, with a cooldown between reported events.
//
// A sample (three signed Q3.12 axes and a millisecond timestamp) is taken on
// in_ch; an event (level, deviation, timestamp) is offered on out_ch. Both are
// valid/ready channels and a transaction completes when valid and ready are
// both high. A sample yields zero or one event.
// The front end forms the sum of squares with one multiplier, pushes it into
// a QUEUE_DEPTH-entry queue and takes a new sample only after that push. The
// back end pops an entry, runs sixteen square-root iterations, then decides
// whether to raise an event, and pops the next entry only after that decision.
// With an empty queue a sample's event reaches out_ch through the front-end
// registers, the queue, the square-root loop and the output register.
// Configuration writes on cfg_we/cfg_index/cfg_wdata apply from the next cycle.
// Reset restores the default registers, clears the last impact time to zero
// and empties the queue. A stalled receiver holds the event; the back end
// waits for the output register and the queue then fills before in_ch stalls.
// ----------------------------------------------------------------------------
module impact_event_detector
  import ied_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ied_in_if.sink                in_ch,
  ied_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  q_item_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_baseline <= RST_GRAVITY_BASELINE;
      cfg_r.impact_threshold <= RST_IMPACT_THRESHOLD;
      cfg_r.medium_threshold <= RST_MEDIUM_THRESHOLD;
      cfg_r.high_threshold   <= RST_HIGH_THRESHOLD;
      cfg_r.cooldown_ms      <= RST_COOLDOWN_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY_BASELINE: cfg_r.gravity_baseline <= cfg_wdata;
        CFG_IMPACT_THRESHOLD: cfg_r.impact_threshold <= cfg_wdata;
        CFG_MEDIUM_THRESHOLD: cfg_r.medium_threshold <= cfg_wdata;
        CFG_HIGH_THRESHOLD:   cfg_r.high_threshold   <= cfg_wdata;
        CFG_COOLDOWN_MS:      cfg_r.cooldown_ms      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ied_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ied_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ied_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/ied_checker.sv =====
// ----------------------------------------------------------------------------
// Impact detector checker
// Port-level assertions on the impact event detector, attached by bind.
// ----------------------------------------------------------------------------
module ied_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_level,
  input logic [15:0] out_deviation,
  input logic [31:0] out_time
);

  logic [31:0] pending_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 32'd1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 32'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) &&
      $stable(out_deviation) && $stable(out_time))
    else $error("Event changed while the receiver stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("Sample port ready right after a transaction.");

  a_no_spurious_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != 32'd0)
    else $error("Event delivered without an outstanding sample.");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Ports not in their reset state after reset.");

endmodule

bind impact_event_detector ied_checker u_ied_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_level     (out_ch.impact_level),
  .out_deviation (out_ch.deviation),
  .out_time      (out_ch.event_time_ms)
);
